[src/vwhc_pkg.sv]
// types and constants for the visual word histogram classifier
// no dependencies
package vwhc_pkg;

   localparam int MAX_WORDS   = 128;
   localparam int DESC_DIM    = 128;
   localparam int MAX_CLASSES = 8;

   localparam int WORD_W  = $clog2(MAX_WORDS);
   localparam int DIM_W   = $clog2(DESC_DIM);
   localparam int CLASS_W = $clog2(MAX_CLASSES);
   localparam int DIST_W  = 39;
   localparam int ACC_W   = 48;

   localparam logic [1:0] OP_CENTER = 2'd0;
   localparam logic [1:0] OP_REF    = 2'd1;
   localparam logic [1:0] OP_DESC   = 2'd2;
   localparam logic [1:0] OP_FINISH = 2'd3;

   localparam logic [0:0] CSR_WORDS   = 1'b0;
   localparam logic [0:0] CSR_CLASSES = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [6:0]  word_index;
      logic [6:0]  dim_index;
      logic [2:0]  class_index;
      logic [15:0] center_value;
      logic [15:0] reference_count;
      logic [7:0]  descriptor_value;
      logic        last_element;
   } req_type;

   typedef struct packed {
      logic              result_kind;
      logic [6:0]        word_out;
      logic [2:0]        class_out;
      logic [DIST_W-1:0] best_distance;
   } rsp_type;

endpackage

[src/vwhc_sqacc.sv]
// shared subtract, square and accumulate unit with running minimum search
// depends on vwhc_pkg
module vwhc_sqacc
   import vwhc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start_in,   // clear accumulator and minimum
   input  logic              valid_in,   // operand pair present
   input  logic [16:0]       a_in,
   input  logic [16:0]       b_in,
   input  logic              close_in,   // candidate sum complete (after last product)
   input  logic [9:0]        cand_in,
   output logic [ACC_W-1:0]  best_d_out,
   output logic [9:0]        best_i_out
);
   logic [16:0]      diff_ff;
   logic             dv_ff;
   logic [33:0]      prod_ff;
   logic             pv_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] best_d_ff;
   logic [9:0]       best_i_ff;
   logic             have_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff   <= 1'b0;
         pv_ff   <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         dv_ff <= valid_in;
         pv_ff <= dv_ff;
         if (start_in) have_ff <= 1'b0;
         else if (close_in) have_ff <= 1'b1;
      end
      diff_ff <= (a_in >= b_in) ? (a_in - b_in) : (b_in - a_in);
      prod_ff <= diff_ff * diff_ff;
      if (start_in || close_in) begin
         acc_ff <= '0;
      end else if (pv_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (close_in && (!have_ff || acc_ff < best_d_ff)) begin
         best_d_ff <= acc_ff;
         best_i_ff <= cand_in;
      end
   end

   assign best_d_out = best_d_ff;
   assign best_i_out = best_i_ff;
endmodule

[src/visual_word_histogram_classifier.sv]
// top level: bag of visual words nearest centroid classifier
// depends on vwhc_pkg and vwhc_sqacc
//
//   channel  direction  handshake       payload
//   req_     in         valid / stall   req_type
//   rsp_     out        valid / stall   rsp_type
//   csr_     in         valid / ready   index, data
//
// store writes and non-last descriptor elements only write their memory; no search starts
// last element: one product per cycle within each of words_in_use candidates
//   through the shared subtract/square/accumulate unit and the centre memory port
// finish: a class search over classes_in_use candidates, then a clear of the
//   histogram, one bin a cycle, then the output step
// after reset the histogram is cleared the same way (req_stall high)
// reset is synchronous; req_stall is high while a search runs or a result waits
module visual_word_histogram_classifier
   import vwhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;  // issue products of one candidate
   localparam logic [2:0] ST_DRAIN = 3'd2;  // wait for pipeline, close candidate
   localparam logic [2:0] ST_BIN   = 3'd3;  // histogram update
   localparam logic [2:0] ST_CLEAR = 3'd4;  // histogram clear sweep
   localparam logic [2:0] ST_OUT   = 3'd5;
   localparam logic [2:0] ST_BINRD = 3'd6;  // read the winning bin

   // memories
   logic [15:0] center_mem [MAX_WORDS*DESC_DIM];
   logic [15:0] ref_mem    [MAX_CLASSES*MAX_WORDS];
   logic [7:0]  desc_mem   [DESC_DIM];
   logic [15:0] hist_mem   [MAX_WORDS];

   logic [2:0]         state_ff, state_in;
   logic               cls_ff;              // finish run in progress
   logic               init_ff;             // clear sweep after reset
   logic [7:0]         words_ff;
   logic [3:0]         classes_ff;
   logic [WORD_W:0]    nwords;
   logic [CLASS_W:0]   nclasses;
   logic [9:0]         cand_ff;             // candidate word or class
   logic [8:0]         elem_ff;             // element within candidate
   logic [2:0]         drain_ff;
   logic               rdv_ff;              // memory read data valid
   logic [15:0]        cen_rd_ff, ref_rd_ff, hist_rd_ff;
   logic [7:0]         desc_rd_ff;
   logic [WORD_W-1:0]  clr_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;
   logic               start, close;
   logic [ACC_W-1:0]   best_d;
   logic [9:0]         best_i;
   logic [8:0]         elem_lim;
   logic [9:0]         cand_lim;
   logic               accept;

   assign nwords   = (words_ff == 8'd0) ? (WORD_W+1)'(1) :
                     (words_ff > 8'(MAX_WORDS)) ? (WORD_W+1)'(MAX_WORDS) :
                     (WORD_W+1)'(words_ff);
   assign nclasses = (classes_ff == 4'd0) ? (CLASS_W+1)'(1) :
                     (classes_ff > 4'(MAX_CLASSES)) ? (CLASS_W+1)'(MAX_CLASSES) :
                     (CLASS_W+1)'(classes_ff);
   assign elem_lim = cls_ff ? 9'(nwords) : 9'(DESC_DIM);
   assign cand_lim = cls_ff ? 10'(nclasses) : 10'(nwords);

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff   <= 8'd100;
         classes_ff <= 4'd5;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WORDS:   words_ff   <= csr_data;
            CSR_CLASSES: classes_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // store writes
   always_ff @(posedge clock) begin
      if (accept && req_data.operation == OP_CENTER)
         center_mem[{req_data.word_index, req_data.dim_index}] <= req_data.center_value;
      if (accept && req_data.operation == OP_REF)
         ref_mem[{req_data.class_index, req_data.word_index}] <= req_data.reference_count;
      if (accept && req_data.operation == OP_DESC)
         desc_mem[req_data.dim_index] <= req_data.descriptor_value;
   end

   // registered reads for the shared unit
   always_ff @(posedge clock) begin
      cen_rd_ff  <= center_mem[{cand_ff[WORD_W-1:0], elem_ff[DIM_W-1:0]}];
      desc_rd_ff <= desc_mem[elem_ff[DIM_W-1:0]];
      ref_rd_ff  <= ref_mem[{cand_ff[CLASS_W-1:0], elem_ff[WORD_W-1:0]}];
      hist_rd_ff <= hist_mem[cls_ff ? elem_ff[WORD_W-1:0] : best_i[WORD_W-1:0]];
   end

   // histogram: increment after a word search, clear sweep after finish or reset
   always_ff @(posedge clock) begin
      if (state_ff == ST_BIN && hist_rd_ff != 16'hFFFF)
         hist_mem[best_i[WORD_W-1:0]] <= hist_rd_ff + 16'd1;
      if (state_ff == ST_CLEAR)
         hist_mem[clr_ff] <= 16'd0;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      start    = 1'b0;
      close    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.operation == OP_FINISH) begin
               state_in = ST_RUN;
               start    = 1'b1;
            end else if (accept && req_data.operation == OP_DESC &&
                         req_data.last_element) begin
               state_in = ST_RUN;
               start    = 1'b1;
            end
         end
         ST_RUN:   if (elem_ff == elem_lim - 9'd1) state_in = ST_DRAIN;
         ST_DRAIN: begin
            if (drain_ff == 3'd3) begin
               close = 1'b1;
               if (cand_ff == cand_lim - 10'd1)
                  state_in = cls_ff ? ST_CLEAR : ST_BINRD;
               else
                  state_in = ST_RUN;
            end
         end
         ST_BINRD: state_in = ST_BIN;
         ST_BIN:   state_in = ST_OUT;
         ST_CLEAR: begin
            if (clr_ff == WORD_W'(MAX_WORDS-1))
               state_in = init_ff ? ST_IDLE : ST_OUT;
         end
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         cls_ff       <= 1'b0;
         elem_ff      <= '0;
         cand_ff      <= '0;
         drain_ff     <= '0;
         clr_ff       <= '0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= (state_ff == ST_RUN);
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (start) begin
            cls_ff  <= (req_data.operation == OP_FINISH);
            elem_ff <= '0;
            cand_ff <= '0;
            clr_ff  <= '0;
         end
         if (state_ff == ST_RUN) begin
            elem_ff  <= elem_ff + 9'd1;
            drain_ff <= '0;
         end
         if (state_ff == ST_DRAIN) begin
            drain_ff <= drain_ff + 3'd1;
            if (close) begin
               elem_ff <= '0;
               cand_ff <= cand_ff + 10'd1;
            end
         end
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + WORD_W'(1);
            if (clr_ff == WORD_W'(MAX_WORDS-1)) init_ff <= 1'b0;
         end
         if (state_ff == ST_OUT) begin
            rsp_valid_ff              <= 1'b1;
            rsp_ff.result_kind        <= cls_ff;
            rsp_ff.word_out           <= cls_ff ? 7'd0 : 7'(best_i);
            rsp_ff.class_out          <= cls_ff ? 3'(best_i) : 3'd0;
            rsp_ff.best_distance      <= (best_d > ACC_W'({DIST_W{1'b1}})) ?
                                         {DIST_W{1'b1}} : DIST_W'(best_d);
         end
      end
   end

   vwhc_sqacc u_sqacc (
      .clock      (clock),
      .reset      (reset),
      .start_in   (start),
      .valid_in   (rdv_ff),
      .a_in       (cls_ff ? {1'b0, hist_rd_ff} : {1'b0, desc_rd_ff, 8'd0}),
      .b_in       (cls_ff ? {1'b0, ref_rd_ff}  : {1'b0, cen_rd_ff}),
      .close_in   (close),
      .cand_in    (cand_ff),
      .best_d_out (best_d),
      .best_i_out (best_i)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // no new transaction while a search runs
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("accepted during search");
   // a result appears only after the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT) else $error("stray result");
   // a held result stays put under stall
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff)) else $error("result lost");
endmodule
